### sv/stnh_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stnh_pkg
// Shared types, constants and the micro-op table for the nearest-hit block.
// ---------------------------------------------------------------------------
package stnh_pkg;

    localparam int COORD_W     = 32;
    localparam int T_FRAC_BITS = 16;
    localparam int Q_W         = T_FRAC_BITS + 1;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int WIDE_W      = 2 * DIFF_W + 1;
    localparam int DIG_W       = 16;
    localparam int NUM_DIG     = (WIDE_W + DIG_W - 1) / DIG_W;
    localparam int OPA_W       = DIG_W * NUM_DIG;
    localparam int PROD_W      = DIG_W + 1 + DIFF_W;
    localparam int ACC_W       = OPA_W + DIFF_W - 9;
    localparam int NUM_UOP     = 24;
    localparam int UOP_IDX_W   = 5;
    localparam int DIG_IDX_W   = 3;
    localparam int STEP_W      = 5;
    localparam int NUM_CFG     = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int Q_CNT_W     = 2;
    localparam int NUM_COMP    = 12;
    localparam int COMP_IDX_W  = 4;

    typedef logic signed [DIFF_W-1:0] comp_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_START_Z = 3'd2,
        CFG_END_X   = 3'd3,
        CFG_END_Y   = 3'd4,
        CFG_END_Z   = 3'd5
    } cfg_idx_t;

    // difference vectors carried per triangle
    typedef enum logic [1:0] {
        VEC_EB = 2'd0,
        VEC_EC = 2'd1,
        VEC_SD = 2'd2,
        VEC_PA = 2'd3
    } vec_sel_t;

    // where a finished accumulation goes
    typedef enum logic [3:0] {
        DST_NONE, DST_N0, DST_N1, DST_N2, DST_DEN, DST_TN,
        DST_EX0, DST_EX1, DST_EX2, DST_BV, DST_BW
    } dst_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_MAC, BK_CHECK, BK_DIV, BK_UPDATE
    } back_state_t;

    typedef struct packed {
        logic              last;
        comp_t [NUM_COMP-1:0] comp;
    } item_t;

    typedef struct packed {
        logic               a_wide;
        logic               a_ex;
        vec_sel_t           a_vec;
        logic [1:0]         a_comp;
        vec_sel_t           b_vec;
        logic [1:0]         b_comp;
        logic               neg;
        dst_t               dst;
    } uop_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_status_t;

    typedef struct packed {
        logic busy;
        logic emit;
    } back_status_t;

    function automatic logic [COMP_IDX_W-1:0] comp_idx(vec_sel_t v, logic [1:0] c);
        logic [COMP_IDX_W-1:0] r;
        r = COMP_IDX_W'({2'b00, v} * 4'd3) + COMP_IDX_W'({2'b00, c});
        return r;
    endfunction

    function automatic uop_t mk_cross(vec_sel_t av, logic [1:0] ac, vec_sel_t bv,
                                      logic [1:0] bc, logic neg, dst_t dst);
        uop_t u;
        u.a_wide = 1'b0;
        u.a_ex   = 1'b0;
        u.a_vec  = av;
        u.a_comp = ac;
        u.b_vec  = bv;
        u.b_comp = bc;
        u.neg    = neg;
        u.dst    = dst;
        return u;
    endfunction

    function automatic uop_t mk_dot(logic ex, logic [1:0] c, vec_sel_t bv,
                                    logic neg, dst_t dst);
        uop_t u;
        u.a_wide = 1'b1;
        u.a_ex   = ex;
        u.a_vec  = VEC_EB;
        u.a_comp = c;
        u.b_vec  = bv;
        u.b_comp = c;
        u.neg    = neg;
        u.dst    = dst;
        return u;
    endfunction

    // micro-op sequence: normal, den, tn, segment cross, bv, -bw
    function automatic uop_t uop_lookup(logic [UOP_IDX_W-1:0] idx);
        uop_t u;
        unique case (idx)
            5'd0:  u = mk_cross(VEC_EB, 2'd1, VEC_EC, 2'd2, 1'b0, DST_NONE);
            5'd1:  u = mk_cross(VEC_EB, 2'd2, VEC_EC, 2'd1, 1'b1, DST_N0);
            5'd2:  u = mk_cross(VEC_EB, 2'd2, VEC_EC, 2'd0, 1'b0, DST_NONE);
            5'd3:  u = mk_cross(VEC_EB, 2'd0, VEC_EC, 2'd2, 1'b1, DST_N1);
            5'd4:  u = mk_cross(VEC_EB, 2'd0, VEC_EC, 2'd1, 1'b0, DST_NONE);
            5'd5:  u = mk_cross(VEC_EB, 2'd1, VEC_EC, 2'd0, 1'b1, DST_N2);
            5'd6:  u = mk_dot(1'b0, 2'd0, VEC_SD, 1'b0, DST_NONE);
            5'd7:  u = mk_dot(1'b0, 2'd1, VEC_SD, 1'b0, DST_NONE);
            5'd8:  u = mk_dot(1'b0, 2'd2, VEC_SD, 1'b0, DST_DEN);
            5'd9:  u = mk_dot(1'b0, 2'd0, VEC_PA, 1'b0, DST_NONE);
            5'd10: u = mk_dot(1'b0, 2'd1, VEC_PA, 1'b0, DST_NONE);
            5'd11: u = mk_dot(1'b0, 2'd2, VEC_PA, 1'b0, DST_TN);
            5'd12: u = mk_cross(VEC_SD, 2'd1, VEC_PA, 2'd2, 1'b0, DST_NONE);
            5'd13: u = mk_cross(VEC_SD, 2'd2, VEC_PA, 2'd1, 1'b1, DST_EX0);
            5'd14: u = mk_cross(VEC_SD, 2'd2, VEC_PA, 2'd0, 1'b0, DST_NONE);
            5'd15: u = mk_cross(VEC_SD, 2'd0, VEC_PA, 2'd2, 1'b1, DST_EX1);
            5'd16: u = mk_cross(VEC_SD, 2'd0, VEC_PA, 2'd1, 1'b0, DST_NONE);
            5'd17: u = mk_cross(VEC_SD, 2'd1, VEC_PA, 2'd0, 1'b1, DST_EX2);
            5'd18: u = mk_dot(1'b1, 2'd0, VEC_EC, 1'b0, DST_NONE);
            5'd19: u = mk_dot(1'b1, 2'd1, VEC_EC, 1'b0, DST_NONE);
            5'd20: u = mk_dot(1'b1, 2'd2, VEC_EC, 1'b0, DST_BV);
            5'd21: u = mk_dot(1'b1, 2'd0, VEC_EB, 1'b1, DST_NONE);
            5'd22: u = mk_dot(1'b1, 2'd1, VEC_EB, 1'b1, DST_NONE);
            5'd23: u = mk_dot(1'b1, 2'd2, VEC_EB, 1'b1, DST_BW);
            default: u = mk_cross(VEC_EB, 2'd0, VEC_EB, 2'd0, 1'b0, DST_NONE);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

### sv/stnh_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stnh_front
// Accepts triangles and forms the edge and segment difference vectors.
// ---------------------------------------------------------------------------
module stnh_front import stnh_pkg::*; (
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [COORD_W-1:0] v0_x,
    input  wire logic signed [COORD_W-1:0] v0_y,
    input  wire logic signed [COORD_W-1:0] v0_z,
    input  wire logic signed [COORD_W-1:0] v1_x,
    input  wire logic signed [COORD_W-1:0] v1_y,
    input  wire logic signed [COORD_W-1:0] v1_z,
    input  wire logic signed [COORD_W-1:0] v2_x,
    input  wire logic signed [COORD_W-1:0] v2_y,
    input  wire logic signed [COORD_W-1:0] v2_z,
    input  wire logic                      last_triangle,
    input  wire logic signed [COORD_W-1:0] seg_reg [NUM_CFG],
    input  wire q_status_t                 q_status,
    output logic                           q_push,
    output item_t                          q_item
);

    function automatic comp_t dsub(logic signed [COORD_W-1:0] a,
                                   logic signed [COORD_W-1:0] b);
        comp_t r;
        r = DIFF_W'(a) - DIFF_W'(b);
        return r;
    endfunction

    // accept whenever the queue has room
    assign s_ready = !q_status.full;
    assign q_push  = s_valid && !q_status.full;

    // eb = B-A, ec = C-A, sd = P-Q, pa = P-A
    always_comb begin
        q_item.last     = last_triangle;
        q_item.comp[0]  = dsub(v1_x, v0_x);
        q_item.comp[1]  = dsub(v1_y, v0_y);
        q_item.comp[2]  = dsub(v1_z, v0_z);
        q_item.comp[3]  = dsub(v2_x, v0_x);
        q_item.comp[4]  = dsub(v2_y, v0_y);
        q_item.comp[5]  = dsub(v2_z, v0_z);
        q_item.comp[6]  = dsub(seg_reg[CFG_START_X], seg_reg[CFG_END_X]);
        q_item.comp[7]  = dsub(seg_reg[CFG_START_Y], seg_reg[CFG_END_Y]);
        q_item.comp[8]  = dsub(seg_reg[CFG_START_Z], seg_reg[CFG_END_Z]);
        q_item.comp[9]  = dsub(seg_reg[CFG_START_X], v0_x);
        q_item.comp[10] = dsub(seg_reg[CFG_START_Y], v0_y);
        q_item.comp[11] = dsub(seg_reg[CFG_START_Z], v0_z);
    end

endmodule
`default_nettype wire

### sv/stnh_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stnh_queue
// Two-entry queue between the front and the back.
// ---------------------------------------------------------------------------
module stnh_queue import stnh_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output item_t      pop_item,
    output q_status_t  status
);

    item_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg, count_next;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item     = mem_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule
`default_nettype wire

### sv/stnh_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stnh_back
// Runs the triple-product test on one shared multiplier, divides out t and
// keeps the nearest hit; reports on the last triangle of a mesh.
// ---------------------------------------------------------------------------
module stnh_back import stnh_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire item_t     q_item,
    input  wire q_status_t q_status,
    output logic           q_pop,
    output logic           m_valid,
    input  wire logic      m_ready,
    output logic           m_any_hit_out,
    output logic [Q_W-1:0] m_nearest_t_out,
    output back_status_t   status
);

    back_state_t            state_reg, state_next;
    logic [UOP_IDX_W-1:0]   uop_idx_reg, uop_idx_next;
    logic [DIG_IDX_W-1:0]   dig_reg, dig_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   hit_reg, hit_next;
    logic [Q_W-1:0]         nearest_reg, nearest_next;
    logic                   any_reg, any_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   out_any_reg, out_any_next;
    logic [Q_W-1:0]         out_t_reg, out_t_next;

    item_t                  item_reg, item_next;
    acc_t                   acc_reg, acc_next;
    wide_t                  n_reg [3];
    wide_t                  ex_reg [3];
    acc_t                   den_reg, tn_reg, bv_reg, bw_reg;
    acc_t                   r_reg, r_next;
    logic [Q_W-1:0]         quo_reg, quo_next;
    logic                   store_en;

    uop_t                      uop;
    comp_t                     a_comp;
    comp_t                     b_comp;
    wide_t                     a_wsel;
    logic signed [OPA_W-1:0]   a_ext;
    logic [DIG_W-1:0]          a_dig;
    logic signed [DIG_W:0]     dig_s;
    logic signed [PROD_W-1:0]  prod;
    acc_t                      prod_ext;
    acc_t                      term;
    acc_t                      acc_sum;
    acc_t                      bvbw;
    logic                      hit_chk;
    acc_t                      r_sh;
    logic                      ge;
    logic [Q_W-1:0]            t_min;

    // multiply one digit of the wide operand by a difference component
    always_comb begin
        uop      = uop_lookup(uop_idx_reg);
        a_comp   = item_reg.comp[comp_idx(uop.a_vec, uop.a_comp)];
        b_comp   = item_reg.comp[comp_idx(uop.b_vec, uop.b_comp)];
        a_wsel   = uop.a_ex ? ex_reg[uop.a_comp] : n_reg[uop.a_comp];
        a_ext    = uop.a_wide ? OPA_W'(a_wsel) : OPA_W'(a_comp);
        a_dig    = a_ext[dig_reg*DIG_W +: DIG_W];
        dig_s    = (dig_reg == DIG_IDX_W'(NUM_DIG - 1)) ? {a_dig[DIG_W-1], a_dig}
                                                       : {1'b0, a_dig};
        prod     = dig_s * b_comp;
        prod_ext = ACC_W'(prod);
        term     = prod_ext <<< (DIG_W * dig_reg);
        acc_sum  = uop.neg ? acc_reg - term : acc_reg + term;
    end

    // hit test on the finished dot products
    always_comb begin
        bvbw    = bv_reg + bw_reg;
        hit_chk = !den_reg[ACC_W-1] && (den_reg != '0)
               && !tn_reg[ACC_W-1] && (tn_reg <= den_reg)
               && !bv_reg[ACC_W-1] && (bv_reg <= den_reg)
               && !bw_reg[ACC_W-1] && (bvbw <= den_reg);
    end

    // one restoring division step
    always_comb begin
        r_sh = (step_reg == '0) ? r_reg : (r_reg <<< 1);
        ge   = (r_sh >= den_reg);
    end

    assign t_min = (hit_reg && (quo_reg < nearest_reg)) ? quo_reg : nearest_reg;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        uop_idx_next = uop_idx_reg;
        dig_next     = dig_reg;
        step_next    = step_reg;
        hit_next     = hit_reg;
        nearest_next = nearest_reg;
        any_next     = any_reg;
        m_valid_next = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        out_any_next = out_any_reg;
        out_t_next   = out_t_reg;
        item_next    = item_reg;
        acc_next     = acc_reg;
        r_next       = r_reg;
        quo_next     = quo_reg;
        store_en     = 1'b0;
        q_pop        = 1'b0;
        status.emit  = 1'b0;
        status.busy  = (state_reg != BK_IDLE);
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    q_pop        = 1'b1;
                    item_next    = q_item;
                    acc_next     = '0;
                    uop_idx_next = '0;
                    dig_next     = '0;
                    state_next   = BK_MAC;
                end
            end
            BK_MAC: begin
                acc_next = acc_sum;
                if (dig_reg == DIG_IDX_W'(NUM_DIG - 1)) begin
                    dig_next     = '0;
                    uop_idx_next = uop_idx_reg + 1'b1;
                    if (uop.dst != DST_NONE) begin
                        store_en = 1'b1;
                        acc_next = '0;
                    end
                    if (uop_idx_reg == UOP_IDX_W'(NUM_UOP - 1)) begin
                        state_next = BK_CHECK;
                    end
                end else begin
                    dig_next = dig_reg + 1'b1;
                end
            end
            BK_CHECK: begin
                hit_next  = hit_chk;
                r_next    = tn_reg;
                quo_next  = '0;
                step_next = '0;
                state_next = hit_chk ? BK_DIV : BK_UPDATE;
            end
            BK_DIV: begin
                r_next    = ge ? r_sh - den_reg : r_sh;
                quo_next  = {quo_reg[Q_W-2:0], ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(T_FRAC_BITS)) begin
                    state_next = BK_UPDATE;
                end
            end
            BK_UPDATE: begin
                if (!item_reg.last) begin
                    nearest_next = t_min;
                    any_next     = any_reg | hit_reg;
                    state_next   = BK_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    status.emit  = 1'b1;
                    m_valid_next = 1'b1;
                    out_any_next = any_reg | hit_reg;
                    out_t_next   = t_min;
                    nearest_next = Q_W'(1 << T_FRAC_BITS);
                    any_next     = 1'b0;
                    state_next   = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            uop_idx_reg <= '0;
            dig_reg     <= '0;
            step_reg    <= '0;
            hit_reg     <= 1'b0;
            nearest_reg <= Q_W'(1 << T_FRAC_BITS);
            any_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            uop_idx_reg <= uop_idx_next;
            dig_reg     <= dig_next;
            step_reg    <= step_next;
            hit_reg     <= hit_next;
            nearest_reg <= nearest_next;
            any_reg     <= any_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        acc_reg     <= acc_next;
        r_reg       <= r_next;
        quo_reg     <= quo_next;
        out_any_reg <= out_any_next;
        out_t_reg   <= out_t_next;
        if (store_en) begin
            unique case (uop.dst)
                DST_N0:  n_reg[0]  <= WIDE_W'(acc_sum);
                DST_N1:  n_reg[1]  <= WIDE_W'(acc_sum);
                DST_N2:  n_reg[2]  <= WIDE_W'(acc_sum);
                DST_DEN: den_reg   <= acc_sum;
                DST_TN:  tn_reg    <= acc_sum;
                DST_EX0: ex_reg[0] <= WIDE_W'(acc_sum);
                DST_EX1: ex_reg[1] <= WIDE_W'(acc_sum);
                DST_EX2: ex_reg[2] <= WIDE_W'(acc_sum);
                DST_BV:  bv_reg    <= acc_sum;
                DST_BW:  bw_reg    <= acc_sum;
                default: ;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_any_hit_out   = out_any_reg;
    assign m_nearest_t_out = out_t_reg;

endmodule
`default_nettype wire

### sv/segment_triangle_nearest_hit.sv
// The back end takes a triangle from the queue and finishes it before it takes the next;
// on a miss it skips the division for t.
// Its work runs on the back end's single 17x33 multiplier (24 products of
// 5 digits each) and the 17-step restoring divider for t.
// A two-entry queue takes two further triangles while the back end works.
// Reset (aresetn low, synchronous) clears the segment to zero, nearest t to 1.0.
`default_nettype none
// ---------------------------------------------------------------------------
// segment_triangle_nearest_hit
// Nearest segment/triangle intersection over a streamed triangle mesh.
// ---------------------------------------------------------------------------
module segment_triangle_nearest_hit import stnh_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [COORD_W-1:0]        cfg_wdata,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [COORD_W-1:0] s_v0_x,
    input  wire logic signed [COORD_W-1:0] s_v0_y,
    input  wire logic signed [COORD_W-1:0] s_v0_z,
    input  wire logic signed [COORD_W-1:0] s_v1_x,
    input  wire logic signed [COORD_W-1:0] s_v1_y,
    input  wire logic signed [COORD_W-1:0] s_v1_z,
    input  wire logic signed [COORD_W-1:0] s_v2_x,
    input  wire logic signed [COORD_W-1:0] s_v2_y,
    input  wire logic signed [COORD_W-1:0] s_v2_z,
    input  wire logic                      s_last_triangle,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_any_hit_out,
    output logic [Q_W-1:0]                 m_nearest_t_out
);

    logic signed [COORD_W-1:0] seg_reg [NUM_CFG];
    q_status_t                 q_status;
    back_status_t              back_status;
    logic                      q_push;
    logic                      q_pop;
    item_t                     push_item;
    item_t                     pop_item;

    // segment registers, out-of-range indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                seg_reg[i] <= '0;
            end
        end else if (cfg_wr_en && (cfg_index <= CFG_END_Z)) begin
            seg_reg[cfg_index] <= cfg_wdata;
        end
    end

    stnh_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .v0_x          (s_v0_x),
        .v0_y          (s_v0_y),
        .v0_z          (s_v0_z),
        .v1_x          (s_v1_x),
        .v1_y          (s_v1_y),
        .v1_z          (s_v1_z),
        .v2_x          (s_v2_x),
        .v2_y          (s_v2_y),
        .v2_z          (s_v2_z),
        .last_triangle (s_last_triangle),
        .seg_reg       (seg_reg),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    stnh_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    stnh_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_item          (pop_item),
        .q_status        (q_status),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_any_hit_out   (m_any_hit_out),
        .m_nearest_t_out (m_nearest_t_out),
        .status          (back_status)
    );

`ifndef SYNTHESIS
    // a result leaves the back end only into the output register
    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.emit |=> m_valid)
        else $error("emitted result not presented");

    // never pop an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // a mesh without hit reports t of exactly 1.0
    a_miss_t_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_any_hit_out) |-> (m_nearest_t_out == Q_W'(1 << T_FRAC_BITS)))
        else $error("miss with t other than 1.0");

    // t never exceeds 1.0
    a_t_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_nearest_t_out[Q_W-1]) |-> (m_nearest_t_out[Q_W-2:0] == '0))
        else $error("t above 1.0");
`endif

endmodule
`default_nettype wire
